// ===== sv/cbs_pkg.sv =====
// Shared types and constants of the constant bandwidth server block.
`default_nettype none

package cbs_pkg;

  localparam int MAX_REPLENISH = 16;
  localparam int REPL_W        = $clog2(MAX_REPLENISH + 1);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);

  localparam logic [31:0] BUDGET_RST = 32'd10000000;
  localparam logic [31:0] PERIOD_RST = 32'd100000000;

  // 32x32 partial products for the bandwidth check
  localparam int MUL_PARTS = 4;
  localparam int MCNT_W    = $clog2(MUL_PARTS + 1);

  typedef enum logic [1:0] {
    CMD_ACTIVATE = 2'd0,
    CMD_ACCOUNT  = 2'd1,
    CMD_YIELD    = 2'd2,
    CMD_RENEW    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_in;
    logic fresh;
    logic clr_new;
    logic set_new;
    logic ld_diff_dl;
    logic ld_diff_late;
    logic mul_start;
    logic mul_step;
    logic yield_drop;
    logic charge;
    logic set_exc;
    logic zero_rt;
    logic sub_late;
    logic repl_clr;
    logic repl_step;
    logic set_lag;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic new_inst;
    logic dmiss;
    logic rt_pos;
    logic ovf;
    logic mul_last;
    logic repl_max;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/cbs_dp.sv =====
// Datapath: server state, configuration, bandwidth check multiplier, result register.
`default_nettype none

module cbs_dp (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [cbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [31:0]                     cfg_data,
  input  wire [62:0]                     in_now,
  input  wire [31:0]                     in_used,
  input  wire cbs_pkg::dp_cmd_t          cmd,
  output cbs_pkg::dp_sts_t               sts,
  output logic [62:0]                    out_dl,
  output logic [63:0]                    out_rem,
  output logic                           out_exc,
  output logic                           out_lag
);

  logic [31:0] budget_r, budget_nxt;
  logic [31:0] period_r, period_nxt;
  logic [63:0] deadline_r, deadline_nxt;
  logic [63:0] runtime_r, runtime_nxt;
  logic        new_r, new_nxt;

  logic [62:0] now_r;
  logic [31:0] used_r;
  logic [63:0] diff_r;
  logic        exc_r;
  logic        lag_r;
  logic [cbs_pkg::REPL_W-1:0] steps_r;

  logic [cbs_pkg::MCNT_W-1:0] mcnt_r;
  logic [1:0]  psel_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] acc_term;

  logic [63:0] now64;
  logic [63:0] dl_minus_now;
  logic [63:0] now_minus_dl;

  assign now64        = {1'b0, now_r};
  assign dl_minus_now = deadline_r - now64;
  assign now_minus_dl = now64 - deadline_r;

  assign sts.new_inst = new_r;
  assign sts.dmiss    = dl_minus_now[63];
  assign sts.rt_pos   = (runtime_r != 64'd0) && !runtime_r[63];
  assign sts.ovf      = acc_r[63];
  assign sts.mul_last = (mcnt_r == cbs_pkg::MCNT_W'(cbs_pkg::MUL_PARTS));
  assign sts.repl_max = (steps_r == cbs_pkg::REPL_W'(cbs_pkg::MAX_REPLENISH));

  always_comb begin
    budget_nxt = budget_r;
    period_nxt = period_r;
    if (cfg_we && cfg_index == cbs_pkg::CFG_BUDGET) budget_nxt = cfg_data;
    if (cfg_we && cfg_index == cbs_pkg::CFG_PERIOD) period_nxt = cfg_data;
  end

  always_comb begin
    if (cmd.fresh) begin
      runtime_nxt = {32'd0, budget_r};
    end else if (cmd.yield_drop || cmd.zero_rt) begin
      runtime_nxt = 64'd0;
    end else if (cmd.charge) begin
      runtime_nxt = runtime_r - {32'd0, used_r};
    end else if (cmd.sub_late) begin
      runtime_nxt = runtime_r - diff_r;
    end else if (cmd.repl_step) begin
      runtime_nxt = runtime_r + {32'd0, budget_r};
    end else begin
      runtime_nxt = runtime_r;
    end
  end

  always_comb begin
    if (cmd.fresh) begin
      deadline_nxt = now64 + {32'd0, period_r};
    end else if (cmd.repl_step) begin
      deadline_nxt = deadline_r + {32'd0, period_r};
    end else begin
      deadline_nxt = deadline_r;
    end
  end

  always_comb begin
    if (cmd.clr_new) begin
      new_nxt = 1'b0;
    end else if (cmd.set_new || cmd.yield_drop) begin
      new_nxt = 1'b1;
    end else begin
      new_nxt = new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r   <= cbs_pkg::BUDGET_RST;
      period_r   <= cbs_pkg::PERIOD_RST;
      deadline_r <= 64'd0;
      runtime_r  <= 64'd0;
      new_r      <= 1'b1;
    end else begin
      budget_r   <= budget_nxt;
      period_r   <= period_nxt;
      deadline_r <= deadline_nxt;
      runtime_r  <= runtime_nxt;
      new_r      <= new_nxt;
    end
  end

  // request capture and per-request scratch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r  <= in_now;
      used_r <= in_used;
    end
    if (cmd.load_in) begin
      exc_r <= 1'b0;
    end else if (cmd.set_exc) begin
      exc_r <= 1'b1;
    end
    if (cmd.load_in) begin
      lag_r <= 1'b0;
    end else if (cmd.set_lag) begin
      lag_r <= 1'b1;
    end
    if (cmd.ld_diff_dl) begin
      diff_r <= dl_minus_now;
    end else if (cmd.ld_diff_late) begin
      diff_r <= now_minus_dl;
    end
    if (cmd.repl_clr) begin
      steps_r <= '0;
    end else if (cmd.repl_step) begin
      steps_r <= steps_r + cbs_pkg::REPL_W'(1);
    end
  end

  // bandwidth check: acc = budget*(deadline-now) - period*runtime, mod 2^64
  always_comb begin
    unique case (mcnt_r[1:0])
      2'd0: begin mul_a = period_r; mul_b = runtime_r[31:0]; end
      2'd1: begin mul_a = period_r; mul_b = runtime_r[63:32]; end
      2'd2: begin mul_a = budget_r; mul_b = diff_r[31:0]; end
      2'd3: begin mul_a = budget_r; mul_b = diff_r[63:32]; end
      default: begin mul_a = period_r; mul_b = runtime_r[31:0]; end
    endcase
  end

  always_comb begin
    unique case (psel_r)
      2'd0: acc_term = -prod_r;
      2'd1: acc_term = -{prod_r[31:0], 32'd0};
      2'd2: acc_term = prod_r;
      2'd3: acc_term = {prod_r[31:0], 32'd0};
      default: acc_term = prod_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcnt_r <= '0;
      acc_r  <= 64'd0;
    end else if (cmd.mul_step) begin
      if (mcnt_r < cbs_pkg::MCNT_W'(cbs_pkg::MUL_PARTS)) begin
        prod_r <= {32'd0, mul_a} * {32'd0, mul_b};
        psel_r <= mcnt_r[1:0];
        mcnt_r <= mcnt_r + cbs_pkg::MCNT_W'(1);
      end
      if (mcnt_r != '0) begin
        acc_r <= acc_r + acc_term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dl  <= deadline_r[62:0];
      out_rem <= runtime_r;
      out_exc <= exc_r;
      out_lag <= lag_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbs_ctrl.sv =====
// Controller: sequences each request through the datapath and owns the handshakes.
`default_nettype none

module cbs_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire cbs_pkg::cmd_t    in_cmd,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  input  wire cbs_pkg::dp_sts_t sts,
  output cbs_pkg::dp_cmd_t      cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_ACT    = 11'b00000000010,
    S_MUL    = 11'b00000000100,
    S_OVF    = 11'b00000001000,
    S_YIELD  = 11'b00000010000,
    S_CHARGE = 11'b00000100000,
    S_MISS   = 11'b00001000000,
    S_SETTLE = 11'b00010000000,
    S_REPL   = 11'b00100000000,
    S_CHECK  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          unique case (in_cmd)
            cbs_pkg::CMD_ACTIVATE: state_nxt = S_ACT;
            cbs_pkg::CMD_ACCOUNT:  state_nxt = S_CHARGE;
            cbs_pkg::CMD_YIELD:    state_nxt = S_YIELD;
            cbs_pkg::CMD_RENEW: begin
              cmd.set_new = 1'b1;
              state_nxt   = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ACT: begin
        if (sts.new_inst || sts.dmiss) begin
          cmd.fresh   = 1'b1;
          cmd.clr_new = sts.new_inst;
          state_nxt   = S_DONE;
        end else begin
          cmd.ld_diff_dl = 1'b1;
          cmd.mul_start  = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_OVF;
      end
      S_OVF: begin
        cmd.fresh = sts.ovf;
        state_nxt = S_DONE;
      end
      S_YIELD: begin
        cmd.yield_drop = sts.rt_pos;
        state_nxt      = S_CHARGE;
      end
      S_CHARGE: begin
        cmd.charge = 1'b1;
        state_nxt  = S_MISS;
      end
      S_MISS: begin
        if (!sts.dmiss && sts.rt_pos) begin
          state_nxt = S_DONE;
        end else begin
          cmd.set_exc  = 1'b1;
          cmd.repl_clr = 1'b1;
          if (sts.dmiss) begin
            // budget left is dropped, lateness charged next cycle unless a new instance is pending
            cmd.ld_diff_late = 1'b1;
            cmd.zero_rt      = sts.rt_pos;
            state_nxt        = S_SETTLE;
          end else if (sts.new_inst) begin
            cmd.fresh   = 1'b1;
            cmd.clr_new = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_REPL;
          end
        end
      end
      S_SETTLE: begin
        if (sts.new_inst) begin
          cmd.fresh   = 1'b1;
          cmd.clr_new = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.sub_late = 1'b1;
          state_nxt    = S_REPL;
        end
      end
      S_REPL: begin
        if (!sts.rt_pos && !sts.repl_max) begin
          cmd.repl_step = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.rt_pos || sts.dmiss) begin
          cmd.fresh   = 1'b1;
          cmd.set_lag = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbs_budget_server.sv =====
// Top level of the constant bandwidth server: budget and deadline keeper for one server.
//
// Requests enter on the in_ stream: in_tuser carries the command (activate, account,
// yield, renew), in_tdata the current time and the used time. Every request yields
// exactly one result on the out_ stream: deadline and remaining budget in out_tdata,
// the exceeded and lagging flags in out_tuser. Budget and period are written on the
// cfg_ port (index 0 budget, index 1 period); the user must write them only while no
// request is in flight, the block does not enforce it. One request is worked at a time;
// activate may run the bandwidth check (four 32x32 partial products through one shared
// multiplier), and the replenish path applies at most MAX_REPLENISH (period, budget)
// steps, one per cycle. A new request is taken the cycle after the result is registered,
// even while that result still waits for out_tready; a stalled receiver holds the
// following result in the controller until the output register frees up.
// Reset (rst_n low, synchronous) restores the default budget and period, clears
// deadline and remaining budget, marks a new instance pending and drops out_tvalid.
`default_nettype none

module cbs_budget_server (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [95:0]  in_tdata,   // [62:0] now, [94:63] used_time, [95] zero
  input  wire  [1:0]   in_tuser,   // [1:0] command
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [127:0] out_tdata,  // [62:0] abs_deadline, [126:63] remaining, [127] zero
  output logic [1:0]   out_tuser,  // [0] exceeded, [1] lagging
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [31:0]  cfg_data
);

  cbs_pkg::dp_cmd_t dp_cmd;
  cbs_pkg::dp_sts_t dp_sts;
  cbs_pkg::cmd_t    in_cmd;
  logic [62:0]      res_dl;
  logic [63:0]      res_rem;
  logic             res_exc;
  logic             res_lag;

  assign cfg_ready = 1'b1;
  assign in_cmd    = cbs_pkg::cmd_t'(in_tuser);

  cbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  cbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_now    (in_tdata[62:0]),
    .in_used   (in_tdata[94:63]),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_dl    (res_dl),
    .out_rem   (res_rem),
    .out_exc   (res_exc),
    .out_lag   (res_lag)
  );

  assign out_tdata = {1'b0, res_rem, res_dl};
  assign out_tuser = {res_lag, res_exc};

  // a lagging reset only follows a budget overrun or a missed deadline
  a_lag_implies_exc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("lagging set without exceeded");

  // one request at a time: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request accepted while one is in flight");

  // at most one writer of the remaining budget per cycle
  a_runtime_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.fresh, dp_cmd.charge, dp_cmd.sub_late, dp_cmd.repl_step,
              dp_cmd.yield_drop, dp_cmd.zero_rt}))
    else $error("conflicting budget updates");

endmodule

`default_nettype wire
